### hw/rtl/tkc_pkg.sv
// ----------------------------------------------------------------------------
// tkc_pkg
// shared types, constants and helpers of the text kind classifier
// ----------------------------------------------------------------------------
`default_nettype none

package tkc_pkg;

  // tally width
  localparam int COUNT_BITS = 32;

  localparam int BYTE_BITS   = 8;
  localparam int KIND_BITS   = 3;
  localparam int OUT_BITS    = 8;
  localparam int OTHER_INC_BITS = 3;

  // byte order mark
  localparam logic [7:0] BOM_BYTE0 = 8'hEF;
  localparam logic [7:0] BOM_BYTE1 = 8'hBB;
  localparam logic [7:0] BOM_BYTE2 = 8'hBF;

  // lead and continuation byte patterns
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;

  // printable range and whitespace
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ASCII     = 3'd0,
    KIND_ASCII_BOM = 3'd1,
    KIND_UTF8      = 3'd2,
    KIND_UTF8_BOM  = 3'd3,
    KIND_BINARY    = 3'd4
  } kind_t;

  // per-text scan state
  typedef struct packed {
    logic [1:0] cont_left;
    logic [1:0] cont_seen;
    logic [1:0] byte_pos;
    logic       bom_so_far;
  } scan_state_t;

  // per-byte tally increments
  typedef struct packed {
    logic                      ascii_inc;
    logic                      rune_inc;
    logic [OTHER_INC_BITS-1:0] other_inc;
    logic                      bom_found;
  } scan_inc_t;

  localparam scan_state_t SCAN_RESET = '{
    cont_left:  2'd0,
    cont_seen:  2'd0,
    byte_pos:   2'd0,
    bom_so_far: 1'b1
  };

  typedef logic [COUNT_BITS-1:0] tally_t;

  // saturating add of a small increment
  function automatic tally_t tally_add(input tally_t x, input logic [OTHER_INC_BITS-1:0] n);
    logic [COUNT_BITS:0] s;
    s = {1'b0, x} + {{(COUNT_BITS + 1 - OTHER_INC_BITS){1'b0}}, n};
    if (s[COUNT_BITS]) begin
      tally_add = {COUNT_BITS{1'b1}};
    end else begin
      tally_add = s[COUNT_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tkc_scan.sv
// ----------------------------------------------------------------------------
// tkc_scan
// per-byte decoder: next scan state and tally increments for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module tkc_scan (
  input  wire logic [7:0]          text_byte,
  input  wire logic                end_of_text,
  input  wire tkc_pkg::scan_state_t cur,
  output tkc_pkg::scan_state_t     nxt,
  output tkc_pkg::scan_inc_t       inc
);
  import tkc_pkg::*;

  logic       is_ascii;
  logic       is_lead4;
  logic       is_lead3;
  logic       is_lead2;
  logic       is_cont;
  logic       bom_match;
  logic       bom_now;
  logic [1:0] left_dec;
  logic [1:0] seen_inc;

  always_comb begin
    is_ascii = ((text_byte >= PRINT_LO) && (text_byte <= PRINT_HI)) ||
               (text_byte == CH_TAB) || (text_byte == CH_LF) || (text_byte == CH_CR);
    is_lead4 = (text_byte & MASK_LEAD4) == PAT_LEAD4;
    is_lead3 = (text_byte & MASK_LEAD3) == PAT_LEAD3;
    is_lead2 = (text_byte & MASK_LEAD2) == PAT_LEAD2;
    is_cont  = (text_byte & MASK_CONT) == PAT_CONT;

    case (cur.byte_pos)
      2'd0:    bom_match = (text_byte == BOM_BYTE0);
      2'd1:    bom_match = (text_byte == BOM_BYTE1);
      2'd2:    bom_match = (text_byte == BOM_BYTE2);
      default: bom_match = 1'b1;
    endcase

    left_dec = cur.cont_left - 2'd1;
    seen_inc = cur.cont_seen + 2'd1;

    nxt = cur;
    inc = '0;

    // bom prefix tracking over the first three bytes
    if (cur.byte_pos != 2'd3) begin
      nxt.bom_so_far = cur.bom_so_far & bom_match;
      nxt.byte_pos   = cur.byte_pos + 2'd1;
    end
    bom_now = nxt.bom_so_far && (cur.byte_pos == 2'd2);

    if ((cur.cont_left != 2'd0) && is_cont) begin
      nxt.cont_left = left_dec;
      nxt.cont_seen = seen_inc;
      if (left_dec == 2'd0) begin
        inc.rune_inc  = ~bom_now;
        nxt.cont_seen = 2'd0;
      end
    end else begin
      // broken sequence: lead and taken continuations become other
      if (cur.cont_left != 2'd0) begin
        inc.other_inc = {1'b0, cur.cont_seen} + 3'd1;
      end
      nxt.cont_left = 2'd0;
      nxt.cont_seen = 2'd0;
      if (is_ascii) begin
        inc.ascii_inc = 1'b1;
      end else if (is_lead4) begin
        nxt.cont_left = 2'd3;
      end else if (is_lead3) begin
        nxt.cont_left = 2'd2;
      end else if (is_lead2) begin
        nxt.cont_left = 2'd1;
      end else begin
        inc.other_inc = inc.other_inc + 3'd1;
      end
    end

    // sequence cut by the end of the text
    if (end_of_text && (nxt.cont_left != 2'd0)) begin
      inc.other_inc = inc.other_inc + {1'b0, nxt.cont_seen} + 3'd1;
    end

    inc.bom_found = nxt.bom_so_far && (nxt.byte_pos == 2'd3);
  end

endmodule

`default_nettype wire

### hw/rtl/text_kind_classifier.sv
// ----------------------------------------------------------------------------
// text_kind_classifier
// classifies a byte stream as ascii, utf-8 (each with or without bom) or binary
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                         | frame
//  --------+-----------+---------------------------------+---------------------
//  in_     | slave     | tdata[7:0] text_byte            | tlast = end_of_text
//  out_    | master    | tdata[2:0] text_kind, rest zero | one per text
//
//  one byte transaction per cycle while in_tready is high; the byte decoder plus
//  one saturating add per tally sits between the input handshake and the tally registers
//  a result goes from the transaction with tlast into the decision stage
//  (tally compare), then into the output register, and shows on out_ from there
//  in_tready drops only while both the decision stage and the output register
//  hold a result and out_tready is low
//  rst_n is synchronous: it empties both stages and restarts the text
//
`default_nettype none

module text_kind_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [tkc_pkg::BYTE_BITS-1:0] in_tdata,   // [7:0] text_byte
  input  wire logic                          in_tlast,   // end_of_text
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [tkc_pkg::OUT_BITS-1:0]       out_tdata   // [2:0] text_kind, [7:3] zero
);
  import tkc_pkg::*;

  // scan state and tallies of the text in flight
  scan_state_t scan_r, scan_nxt;
  scan_state_t scan_step;
  scan_inc_t   inc;
  tally_t      ascii_r, ascii_nxt, ascii_sum;
  tally_t      rune_r,  rune_nxt,  rune_sum;
  tally_t      other_r, other_nxt, other_sum;

  // decision stage: final tallies of a finished text
  logic        dec_valid_r, dec_valid_nxt;
  tally_t      dec_ascii_r, dec_ascii_nxt;
  tally_t      dec_rune_r,  dec_rune_nxt;
  tally_t      dec_other_r, dec_other_nxt;
  logic        dec_bom_r,   dec_bom_nxt;
  kind_t       dec_kind;

  // output register
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r,  out_kind_nxt;

  logic        in_xfer;
  logic        out_load_ok;
  logic        dec_move;

  tkc_scan u_scan (
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .cur         (scan_r),
    .nxt         (scan_step),
    .inc         (inc)
  );

  // handshake: the output register frees when empty or taken,
  // the decision stage frees when empty or moving on
  always_comb begin
    out_load_ok = ~out_valid_r | out_tready;
    dec_move    = dec_valid_r & out_load_ok;
    in_tready   = ~dec_valid_r | out_load_ok;
    in_xfer     = in_tvalid & in_tready;
  end

  // tally updates, one saturating add each
  always_comb begin
    ascii_sum = tally_add(ascii_r, {{(OTHER_INC_BITS-1){1'b0}}, inc.ascii_inc});
    rune_sum  = tally_add(rune_r,  {{(OTHER_INC_BITS-1){1'b0}}, inc.rune_inc});
    other_sum = tally_add(other_r, inc.other_inc);
  end

  // scan stage: on the last byte the tallies go to the decision stage
  // and the scan restarts for the next text
  always_comb begin
    scan_nxt      = scan_r;
    ascii_nxt     = ascii_r;
    rune_nxt      = rune_r;
    other_nxt     = other_r;
    dec_valid_nxt = dec_valid_r & ~dec_move;
    dec_ascii_nxt = dec_ascii_r;
    dec_rune_nxt  = dec_rune_r;
    dec_other_nxt = dec_other_r;
    dec_bom_nxt   = dec_bom_r;
    if (in_xfer) begin
      if (in_tlast) begin
        scan_nxt      = SCAN_RESET;
        ascii_nxt     = '0;
        rune_nxt      = '0;
        other_nxt     = '0;
        dec_valid_nxt = 1'b1;
        dec_ascii_nxt = ascii_sum;
        dec_rune_nxt  = rune_sum;
        dec_other_nxt = other_sum;
        dec_bom_nxt   = inc.bom_found;
      end else begin
        scan_nxt  = scan_step;
        ascii_nxt = ascii_sum;
        rune_nxt  = rune_sum;
        other_nxt = other_sum;
      end
    end
  end

  // decision: clean text is ascii or utf-8 by rune count,
  // otherwise ascii only when ascii bytes outnumber other bytes
  always_comb begin
    if (dec_other_r == '0) begin
      if (dec_rune_r == '0) begin
        dec_kind = dec_bom_r ? KIND_ASCII_BOM : KIND_ASCII;
      end else begin
        dec_kind = dec_bom_r ? KIND_UTF8_BOM : KIND_UTF8;
      end
    end else if (dec_ascii_r > dec_other_r) begin
      dec_kind = dec_bom_r ? KIND_ASCII_BOM : KIND_ASCII;
    end else begin
      dec_kind = KIND_BINARY;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_tready;
    out_kind_nxt  = out_kind_r;
    if (dec_move) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = dec_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= SCAN_RESET;
      ascii_r     <= '0;
      rune_r      <= '0;
      other_r     <= '0;
      dec_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      scan_r      <= scan_nxt;
      ascii_r     <= ascii_nxt;
      rune_r      <= rune_nxt;
      other_r     <= other_nxt;
      dec_valid_r <= dec_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dec_ascii_r <= dec_ascii_nxt;
    dec_rune_r  <= dec_rune_nxt;
    dec_other_r <= dec_other_nxt;
    dec_bom_r   <= dec_bom_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_BITS-KIND_BITS){1'b0}}, out_kind_r};

endmodule

`default_nettype wire

### hw/rtl/tkc_checker.sv
// ----------------------------------------------------------------------------
// tkc_checker
// port-level checks of the text kind classifier, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tkc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       in_tlast,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // a fresh result follows a last-byte transaction through the decision stage
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a finished text");

  // input backpressure only comes from a stalled output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output is free");

endmodule

bind text_kind_classifier tkc_checker u_tkc_checker (.*);

`default_nettype wire

### tb/sv/tb_text_kind_classifier.sv
// ----------------------------------------------------------------------------
// tb_text_kind_classifier
// self-checking bench for the text kind classifier: texts go in as byte
// transactions with tlast on the final byte, and a scoreboard predicts the kind
// of each text and checks every result transaction against it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_text_kind_classifier;
  import tkc_pkg::*;

  // scoreboard: tracks the text being streamed and queues predicted kinds
  class kind_scoreboard;
    logic [1:0] cont_left;
    logic [1:0] cont_seen;
    logic [1:0] byte_pos;
    bit         bom_match;
    tally_t     ascii_n;
    tally_t     rune_n;
    tally_t     other_n;
    kind_t      pending_kinds[$];
    int         errors;

    function new();
      errors = 0;
      restart_text();
    endfunction

    function void restart_text();
      cont_left = 2'd0;
      cont_seen = 2'd0;
      byte_pos  = 2'd0;
      bom_match = 1'b1;
      ascii_n   = '0;
      rune_n    = '0;
      other_n   = '0;
    endfunction

    // tally add that sticks at all ones
    function tally_t sat_bump(tally_t x, int unsigned n);
      logic [COUNT_BITS:0] s;
      s = {1'b0, x} + n;
      if (s[COUNT_BITS]) return '1;
      return s[COUNT_BITS-1:0];
    endfunction

    // a byte that is not inside a multi-byte sequence
    function void tally_fresh_byte(logic [7:0] b);
      if ((b >= PRINT_LO && b <= PRINT_HI) || b == CH_TAB || b == CH_CR || b == CH_LF) begin
        ascii_n = sat_bump(ascii_n, 1);
      end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
        cont_left = 2'd3;
        cont_seen = 2'd0;
      end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
        cont_left = 2'd2;
        cont_seen = 2'd0;
      end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
        cont_left = 2'd1;
        cont_seen = 2'd0;
      end else begin
        other_n = sat_bump(other_n, 1);
      end
    endfunction

    // one accepted input transaction
    function void note_byte(logic [7:0] b, bit last);
      logic [1:0] pos;
      logic [7:0] bom_ref;
      bit         bom_now;
      kind_t      kind;
      pos = byte_pos;
      if (pos < 3) begin
        bom_ref = (pos == 0) ? BOM_BYTE0 : (pos == 1) ? BOM_BYTE1 : BOM_BYTE2;
        if (b != bom_ref) bom_match = 1'b0;
        byte_pos = pos + 2'd1;
      end
      bom_now = bom_match && pos == 2;

      if (cont_left != 0) begin
        if ((b & MASK_CONT) == PAT_CONT) begin
          cont_left = cont_left - 2'd1;
          cont_seen = cont_seen + 2'd1;
          if (cont_left == 0) begin
            // the bom itself is not a rune
            if (!bom_now) rune_n = sat_bump(rune_n, 1);
            cont_seen = 2'd0;
          end
        end else begin
          // broken sequence: lead and taken continuations count as other
          other_n = sat_bump(other_n, 1 + cont_seen);
          cont_left = 2'd0;
          cont_seen = 2'd0;
          tally_fresh_byte(b);
        end
      end else begin
        tally_fresh_byte(b);
      end

      if (!last) return;

      // sequence cut short by the end of the text
      if (cont_left != 0) other_n = sat_bump(other_n, 1 + cont_seen);

      if (other_n == 0) kind = (rune_n == 0) ? KIND_ASCII : KIND_UTF8;
      else kind = (ascii_n > other_n) ? KIND_ASCII : KIND_BINARY;
      if (bom_match && byte_pos == 3) begin
        if (kind == KIND_ASCII) kind = KIND_ASCII_BOM;
        else if (kind == KIND_UTF8) kind = KIND_UTF8_BOM;
      end
      pending_kinds.push_back(kind);
      restart_text();
    endfunction

    // one accepted result transaction
    function void check_kind(logic [OUT_BITS-1:0] data);
      kind_t want;
      if (pending_kinds.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d", $time, data[2:0]);
        return;
      end
      want = pending_kinds.pop_front();
      if (data[KIND_BITS-1:0] !== want) begin
        errors++;
        $display("%0t: text_kind mismatch, expected %0d, actual %0d", $time, want,
                 data[KIND_BITS-1:0]);
      end
      if (data[OUT_BITS-1:KIND_BITS] !== '0) begin
        errors++;
        $display("%0t: tdata pad mismatch, expected 0, actual %0h", $time,
                 data[OUT_BITS-1:KIND_BITS]);
      end
    endfunction

    function int waiting();
      return pending_kinds.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [BYTE_BITS-1:0]    in_tdata;
  logic                    in_tlast;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_BITS-1:0]     out_tdata;

  kind_scoreboard sb;
  logic [7:0]     text_bytes[$];   // the text about to be streamed
  int             random_bytes;    // random-part bytes built for sending so far
  int             text_count;
  bit             send_steady;     // sender never idles while set
  bit             take_steady;     // receiver never stalls while set

  text_kind_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watch both channels at the rising edge; results trail tlast by the decision stage
  // and the output register, so noting the input before checking the output is safe
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_kind(out_tdata);
    end
  end

  // result side: a random stall before each result, none while take_steady
  initial begin : result_side
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = take_steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // one byte transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
    end
    text_count++;
  endtask

  // hold the input off until every predicted kind has come out
  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid = 1'b0;
    while (sb.waiting() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    @(negedge clk);
  endtask

  // lead byte of a sequence with n continuation bytes, random payload bits
  function automatic logic [7:0] lead_byte(int n);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (n)
      1:       return {3'b110, r[4:0]};
      2:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    return {2'b10, r[5:0]};
  endfunction

  // random text: mostly well-formed ascii and runes, some noise and broken
  // sequences, sometimes behind a full or partial bom
  function automatic void build_random_text();
    int n_tokens;
    int r;
    int n;
    int k;
    text_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 25) begin
      text_bytes.push_back(BOM_BYTE0);
      text_bytes.push_back(BOM_BYTE1);
      text_bytes.push_back(BOM_BYTE2);
    end else if (r < 32) begin
      text_bytes.push_back(BOM_BYTE0);
      if ($urandom_range(0, 1)) text_bytes.push_back(BOM_BYTE1);
    end
    n_tokens = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
    // a bare bom is a text of its own now and then
    if (text_bytes.size() == 3 && $urandom_range(0, 7) == 0) n_tokens = 0;
    for (int t = 0; t < n_tokens; t++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        text_bytes.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
      end else if (r < 48) begin
        k = $urandom_range(0, 2);
        text_bytes.push_back(k == 0 ? CH_TAB : k == 1 ? CH_LF : CH_CR);
      end else if (r < 76) begin
        n = (r < 58) ? 1 : (r < 68) ? 2 : 3;
        text_bytes.push_back(lead_byte(n));
        repeat (n) text_bytes.push_back(cont_byte());
      end else if (r < 88) begin
        // broken: too few continuations, maybe followed by a breaking byte
        n = $urandom_range(1, 3);
        text_bytes.push_back(lead_byte(n));
        repeat ($urandom_range(0, n - 1)) text_bytes.push_back(cont_byte());
        if ($urandom_range(0, 2) != 0) begin
          k = $urandom_range(0, 191);
          text_bytes.push_back(k < 128 ? k[7:0] : k[7:0] + 8'd64);
        end
      end else begin
        text_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  initial begin
    sb = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    send_steady  = 1'b0;
    take_steady  = 1'b0;
    random_bytes = 0;
    text_count   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed texts
    text_bytes = '{8'h20, 8'h7E};                     // printable extremes
    send_text();
    text_bytes = '{8'h00};                            // lone control byte
    send_text();
    text_bytes = '{8'hEF, 8'hBB, 8'hBF};              // bom and nothing else
    send_text();
    text_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'hC3, 8'hA9}; // bom then a 2-byte rune
    send_text();
    text_bytes = '{8'hEF, 8'hBB};                     // short text, bom cut off
    send_text();
    text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};       // 4-byte rune
    send_text();
    text_bytes = '{8'hC3, 8'h41};                     // broken by an ascii byte
    send_text();
    text_bytes = '{8'h09, 8'h0A, 8'h0D, 8'h7F, 8'hFF}; // whitespace vs others
    send_text();
    drain();

    // random texts
    while (random_bytes < 850) begin
      if ($urandom_range(0, 9) == 0) send_steady = !send_steady;
      if ($urandom_range(0, 9) == 0) take_steady = !take_steady;
      build_random_text();
      random_bytes += text_bytes.size();
      send_text();
      if (text_count % 40 == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (sb.waiting() != 0)
        $display("%0t: results missing, expected %0d more, actual 0", $time, sb.waiting());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
